// ===== hw/rtl/sads_pkg.sv =====
// Shared types and constants for the spectrum attack/decay smoother.
`timescale 1ns / 1ps

package sads_pkg;

  // Geometry of the cascade and of the level store.
  localparam int BINS     = 512;
  localparam int CASCADES = 3;
  localparam int DEPTH    = CASCADES * BINS;
  localparam int IDX_W    = $clog2(DEPTH);

  // Field widths.
  localparam int CASC_W = 2;
  localparam int BIN_W  = 9;
  localparam int VAL_W  = 32;
  localparam int COEF_W = 16;
  localparam int IDXR_W = 3;

  // Coefficient sets in the register map.
  localparam int COEF_SETS = 3;

  // Configuration register indexes.
  localparam logic [IDXR_W-1:0] REG_ATTACK_C0    = 3'd0;
  localparam logic [IDXR_W-1:0] REG_DECAY_C0     = 3'd1;
  localparam logic [IDXR_W-1:0] REG_ATTACK_C1    = 3'd2;
  localparam logic [IDXR_W-1:0] REG_DECAY_C1     = 3'd3;
  localparam logic [IDXR_W-1:0] REG_ATTACK_C2    = 3'd4;
  localparam logic [IDXR_W-1:0] REG_DECAY_C2     = 3'd5;
  localparam logic [IDXR_W-1:0] REG_CORRECT_ZERO = 3'd6;

  // One input request.
  typedef struct packed {
    logic [CASC_W-1:0]       cascade;
    logic [BIN_W-1:0]        bin;
    logic signed [VAL_W-1:0] spectral_value;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [CASC_W-1:0]       out_cascade;
    logic [BIN_W-1:0]        out_bin;
    logic [VAL_W-1:0]        level;
    logic signed [VAL_W-1:0] dc_level;
  } out_item_t;

  // Attack and decay coefficients of one cascade.
  typedef struct packed {
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] decay;
  } coef_row_t;

  // Access to the level store.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/sads_cfg_regs.sv =====
// Configuration registers: per-cascade coefficients and the DC correction flag.
`timescale 1ns / 1ps

module sads_cfg_regs
  import sads_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [IDXR_W-1:0] cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata,
  input  logic [CASC_W-1:0] coef_sel,
  output coef_row_t         coef_row,
  output logic              correct_zero
);

  logic [COEF_W-1:0] attack [COEF_SETS];
  logic [COEF_W-1:0] decay  [COEF_SETS];

  // Register writes; indexes beyond the map are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_SETS; i++) begin
        attack[i] <= '0;
        decay[i]  <= '0;
      end
      correct_zero <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ATTACK_C0:    attack[0]    <= cfg_wdata;
        REG_DECAY_C0:     decay[0]     <= cfg_wdata;
        REG_ATTACK_C1:    attack[1]    <= cfg_wdata;
        REG_DECAY_C1:     decay[1]     <= cfg_wdata;
        REG_ATTACK_C2:    attack[2]    <= cfg_wdata;
        REG_DECAY_C2:     decay[2]     <= cfg_wdata;
        REG_CORRECT_ZERO: correct_zero <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Coefficient pair of the requested cascade.
  assign coef_row.attack = attack[coef_sel];
  assign coef_row.decay  = decay[coef_sel];

endmodule

// ===== hw/rtl/sads_level_mem.sv =====
// Level store: one-port-read, one-port-write synchronous RAM with a clearing sweep.
`timescale 1ns / 1ps

module sads_level_mem
  import sads_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  mem_req_t         mem_req,
  output logic [VAL_W-1:0] rd_data,
  output logic             busy
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] clr_addr;

  // Clearing sweep after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == IDX_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Write port: the sweep owns it while clearing.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sads_pipe.sv =====
// Scaling and smoothing pipeline with read-modify-write of the level store.
`timescale 1ns / 1ps

module sads_pipe
  import sads_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  in_item_t          sample,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  output logic [CASC_W-1:0] coef_sel,
  input  coef_row_t         coef_row,
  input  logic              correct_zero,
  output mem_req_t          mem_req,
  input  logic [VAL_W-1:0]  mem_rd_data,
  input  logic              mem_busy
);

  localparam logic [VAL_W-1:0] SQRT2_Q30 = 32'd1518500250;
  localparam logic [63:0]      ROUND_Q30 = 64'h0000_0000_2000_0000;
  localparam logic [47:0]      ROUND_Q16 = 48'h0000_0000_8000;

  // Multiply by sqrt2 in Q2.30, round half up, saturate to 32 bits.
  function automatic logic [VAL_W-1:0] mul_sqrt2(input logic [VAL_W-1:0] x);
    logic [63:0] prod;
    logic [33:0] q;
    prod = 64'(x) * 64'(SQRT2_Q30) + ROUND_Q30;
    q    = prod[63:30];
    return (q[33:32] != 2'b00) ? '1 : q[31:0];
  endfunction

  // Smoothing term k * diff in Q0.16, rounded half up.
  function automatic logic [VAL_W-1:0] smooth_mag(input logic [VAL_W-1:0] diff,
                                                  input logic [COEF_W-1:0] k);
    logic [47:0] prod;
    prod = 48'(diff) * 48'(k) + ROUND_Q16;
    return prod[47:16];
  endfunction

  // Stage valids and handshake.
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;
  logic free1, free2, free3, free4, free5, free6;
  logic haz, acc;

  // Stage 1: saturated indexes and the unscaled new value.
  logic [CASC_W-1:0] s1_c;
  logic [BIN_W-1:0]  s1_b;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_zero, s1_mul;
  logic [VAL_W-1:0]  s1_sv, s1_nv;
  coef_row_t         s1_coef;

  // Stage 2: after the DC correction multiply.
  logic [CASC_W-1:0] s2_c;
  logic [BIN_W-1:0]  s2_b;
  logic [IDX_W-1:0]  s2_idx;
  logic              s2_zero;
  logic [VAL_W-1:0]  s2_sv, s2_nv;
  coef_row_t         s2_coef;

  // Stage 3: fully scaled value; old level arrives from the store.
  logic [CASC_W-1:0] s3_c;
  logic [BIN_W-1:0]  s3_b;
  logic [IDX_W-1:0]  s3_idx;
  logic              s3_zero;
  logic [VAL_W-1:0]  s3_sv, s3_nv;
  coef_row_t         s3_coef;

  // Stage 4: differences and selected coefficients.
  logic [CASC_W-1:0] s4_c;
  logic [BIN_W-1:0]  s4_b;
  logic [IDX_W-1:0]  s4_idx;
  logic              s4_zero, s4_up, s4_dup;
  logic [VAL_W-1:0]  s4_sv, s4_nv, s4_diff, s4_ddiff, s4_dc_cur;
  logic [COEF_W-1:0] s4_k, s4_kd;

  // Stage 5: smoothing terms.
  logic [CASC_W-1:0] s5_c;
  logic [BIN_W-1:0]  s5_b;
  logic [IDX_W-1:0]  s5_idx;
  logic              s5_zero, s5_up, s5_dup;
  logic [VAL_W-1:0]  s5_sv, s5_nv, s5_mag, s5_dmag, s5_dc_cur;

  // Per-cascade DC levels.
  logic [VAL_W-1:0] dc_store [CASCADES];

  // Combinational values.
  logic [CASC_W-1:0] in_c;
  logic [BIN_W-1:0]  in_b;
  logic [IDX_W-1:0]  in_idx;
  logic              in_zero;
  logic [VAL_W-1:0]  in_nv, in_sv;
  logic [VAL_W-1:0]  s2_shift, s2_scaled;
  logic [VAL_W-1:0]  s3_old, s3_dc_old;
  logic [32:0]       s3_old_x, s3_sv_x;
  logic [32:0]       s3_ddiff_w;
  logic              s3_up, s3_dup, s3_decay, s3_ddecay;
  logic [VAL_W-1:0]  lvl, ndc;
  logic              dc_wr;

  // Ready chain from the result register back to the input.
  always_comb begin
    free6        = !result_valid || !result_stall;
    adv5         = v5 && free6;
    free5        = !v5 || adv5;
    adv4         = v4 && free5;
    free4        = !v4 || adv4;
    adv3         = v3 && free4;
    free3        = !v3 || adv3;
    haz          = (v3 && s3_idx == s2_idx) || (v4 && s4_idx == s2_idx) ||
                   (v5 && s5_idx == s2_idx);
    adv2         = v2 && free3 && !haz;
    free2        = !v2 || adv2;
    adv1         = v1 && free2;
    free1        = !v1 || adv1;
    sample_stall = mem_busy || !free1;
    acc          = sample_valid && !sample_stall;
  end

  // Input decode: saturate cascade and bin, form the store address.
  always_comb begin
    in_c    = (int'(sample.cascade) >= CASCADES) ? CASC_W'(CASCADES - 1) : sample.cascade;
    in_b    = (int'(sample.bin) >= BINS) ? BIN_W'(BINS - 1) : sample.bin;
    in_idx  = IDX_W'(int'(in_c) * BINS + int'(in_b));
    in_zero = (in_b == '0);
    in_sv   = sample.spectral_value;
    if (in_zero) begin
      in_nv = in_sv[VAL_W-1] ? (~in_sv + 1'b1) : in_sv;
    end else begin
      in_nv = in_sv[VAL_W-1] ? '0 : in_sv;
    end
  end

  assign coef_sel = in_c;

  // Cascade gain: shift by c/2 with saturation, then sqrt2 for odd cascades.
  always_comb begin
    if (s2_c[1]) begin
      s2_shift = s2_nv[VAL_W-1] ? '1 : {s2_nv[VAL_W-2:0], 1'b0};
    end else begin
      s2_shift = s2_nv;
    end
    s2_scaled = s2_c[0] ? mul_sqrt2(s2_shift) : s2_shift;
  end

  // Compare against the stored levels and pick the coefficients.
  always_comb begin
    s3_old     = mem_rd_data;
    s3_dc_old  = (dc_wr && s5_c == s3_c) ? ndc : dc_store[s3_c];
    s3_up      = (s3_old >= s3_nv);
    s3_decay   = (s3_nv < s3_old);
    s3_old_x   = {s3_dc_old[VAL_W-1], s3_dc_old};
    s3_sv_x    = {s3_sv[VAL_W-1], s3_sv};
    s3_dup     = ($signed(s3_dc_old) >= $signed(s3_sv));
    s3_ddecay  = ($signed(s3_sv) < $signed(s3_dc_old));
    s3_ddiff_w = s3_dup ? (s3_old_x - s3_sv_x) : (s3_sv_x - s3_old_x);
  end

  // Final sums; both land between the old and the new value.
  always_comb begin
    lvl   = s5_up ? (s5_nv + s5_mag) : (s5_nv - s5_mag);
    ndc   = s5_dup ? (s5_sv + s5_dmag) : (s5_sv - s5_dmag);
    dc_wr = adv5 && s5_zero;
  end

  // Level store access: read when entering stage 3, write on leaving stage 5.
  always_comb begin
    mem_req.rd_en   = adv2;
    mem_req.rd_addr = s2_idx;
    mem_req.wr_en   = adv5;
    mem_req.wr_addr = s5_idx;
    mem_req.wr_data = lvl;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= acc;
      end
      if (free2) begin
        v2 <= adv1;
      end
      if (free3) begin
        v3 <= adv2;
      end
      if (free4) begin
        v4 <= adv3;
      end
      if (free5) begin
        v5 <= adv4;
      end
      if (free6) begin
        result_valid <= adv5;
      end
    end
  end

  // DC level registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CASCADES; i++) begin
        dc_store[i] <= '0;
      end
    end else if (dc_wr) begin
      dc_store[s5_c] <= ndc;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_c    <= in_c;
      s1_b    <= in_b;
      s1_idx  <= in_idx;
      s1_zero <= in_zero;
      s1_mul  <= in_zero && correct_zero;
      s1_sv   <= in_sv;
      s1_nv   <= in_nv;
      s1_coef <= coef_row;
    end
    if (adv1) begin
      s2_c    <= s1_c;
      s2_b    <= s1_b;
      s2_idx  <= s1_idx;
      s2_zero <= s1_zero;
      s2_sv   <= s1_sv;
      s2_nv   <= s1_mul ? mul_sqrt2(s1_nv) : s1_nv;
      s2_coef <= s1_coef;
    end
    if (adv2) begin
      s3_c    <= s2_c;
      s3_b    <= s2_b;
      s3_idx  <= s2_idx;
      s3_zero <= s2_zero;
      s3_sv   <= s2_sv;
      s3_nv   <= s2_scaled;
      s3_coef <= s2_coef;
    end
    if (adv3) begin
      s4_c      <= s3_c;
      s4_b      <= s3_b;
      s4_idx    <= s3_idx;
      s4_zero   <= s3_zero;
      s4_sv     <= s3_sv;
      s4_nv     <= s3_nv;
      s4_up     <= s3_up;
      s4_diff   <= s3_up ? (s3_old - s3_nv) : (s3_nv - s3_old);
      s4_k      <= s3_decay ? s3_coef.decay : s3_coef.attack;
      s4_dup    <= s3_dup;
      s4_ddiff  <= s3_ddiff_w[VAL_W-1:0];
      s4_kd     <= s3_ddecay ? s3_coef.decay : s3_coef.attack;
      s4_dc_cur <= s3_dc_old;
    end
    if (adv4) begin
      s5_c      <= s4_c;
      s5_b      <= s4_b;
      s5_idx    <= s4_idx;
      s5_zero   <= s4_zero;
      s5_sv     <= s4_sv;
      s5_nv     <= s4_nv;
      s5_up     <= s4_up;
      s5_dup    <= s4_dup;
      s5_mag    <= smooth_mag(s4_diff, s4_k);
      s5_dmag   <= smooth_mag(s4_ddiff, s4_kd);
      // A DC update of the same cascade retiring now is newer than the copy.
      s5_dc_cur <= (dc_wr && s5_c == s4_c) ? ndc : s4_dc_cur;
    end
    if (adv5) begin
      result.out_cascade <= s5_c;
      result.out_bin     <= s5_b;
      result.level       <= lvl;
      result.dc_level    <= s5_zero ? ndc : s5_dc_cur;
    end
  end

`ifndef ASSERT_OFF
  // A retiring write never has a younger item of the same entry behind it.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    adv5 |-> !(v3 && s3_idx == s5_idx) && !(v4 && s4_idx == s5_idx))
    else $error("level store entry in flight twice");

  // Read data for a waiting stage 3 item must not move.
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && $past(v3) && !$past(adv2) |-> $stable(mem_rd_data))
    else $error("level read data changed under a held item");

  // The pipeline stays empty during the clearing sweep.
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !(v1 || v2 || v3 || v4 || v5 || result_valid))
    else $error("item in flight during the clearing sweep");
`endif

endmodule

// ===== hw/rtl/spectrum_attack_decay_smoother_top.sv =====
// Top level of the spectrum attack/decay smoother.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                   Payload
//  sample    in         sample_valid/sample_stall   in_item_t
//  result    out        result_valid/result_stall   out_item_t
//  config    in         cfg_wr_en                   cfg_index, cfg_wdata
//
//  One request per cycle unless a stall or a repeated store entry holds the flow.
//  A cascade and bin pair that repeats within three requests waits in stage 2
//  until the older one leaves stage 5: the level store read-modify-write loop
//  spans stages 3 to 5. After reset the level store clears all 1536 entries;
//  sample_stall stays high meanwhile, configuration writes are taken throughout.
//  A stalled result holds in the output register while requests fill the stages.

module spectrum_attack_decay_smoother_top
  import sads_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  in_item_t          sample,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              cfg_wr_en,
  input  logic [IDXR_W-1:0] cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata
);

  logic [CASC_W-1:0] coef_sel;
  coef_row_t         coef_row;
  logic              correct_zero;
  mem_req_t          mem_req;
  logic [VAL_W-1:0]  mem_rd_data;
  logic              mem_busy;

  // Coefficient and mode registers.
  sads_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .coef_sel     (coef_sel),
    .coef_row     (coef_row),
    .correct_zero (correct_zero)
  );

  // Level store.
  sads_level_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .mem_req (mem_req),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  // Scaling and smoothing pipeline.
  sads_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .coef_sel     (coef_sel),
    .coef_row     (coef_row),
    .correct_zero (correct_zero),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data),
    .mem_busy     (mem_busy)
  );

endmodule
